/* rtl/png_unf_pkg.sv */
package png_unf_pkg;

	// Filter type codes as held for the current row.
	typedef logic [2:0] filter_t;

	localparam filter_t FILT_NONE  = 3'd0;
	localparam filter_t FILT_SUB   = 3'd1;
	localparam filter_t FILT_UP    = 3'd2;
	localparam filter_t FILT_AVG   = 3'd3;
	localparam filter_t FILT_PAETH = 3'd4;
	localparam filter_t FILT_BAD   = 3'd7;

	// Bytes per RGBA pixel.
	localparam int PIXEL_BYTES = 4;

	// Width of the row length register.
	localparam int CFG_W = 13;

endpackage

/* rtl/png_unf_predict.sv */
module png_unf_predict
	import png_unf_pkg::*;
(
	input  filter_t    filt,
	input  logic [7:0] filtered,
	input  logic [7:0] left,
	input  logic [7:0] above,
	input  logic [7:0] above_left,
	output logic [7:0] recon,
	output logic       bad
);

	logic signed [9:0] a_s, b_s, c_s;
	logic signed [9:0] dist_a, dist_b, dist_c;
	logic [9:0]        abs_a, abs_b, abs_c;
	logic [7:0]        paeth;
	logic [8:0]        avg_sum;
	logic [7:0]        pred;

	// Paeth distances: |p-a| = |b-c|, |p-b| = |a-c|, |p-c| = |a+b-2c|.
	always_comb begin
		a_s    = signed'({2'b00, left});
		b_s    = signed'({2'b00, above});
		c_s    = signed'({2'b00, above_left});
		dist_a = b_s - c_s;
		dist_b = a_s - c_s;
		dist_c = a_s + b_s - c_s - c_s;
		abs_a  = dist_a[9] ? 10'(-dist_a) : 10'(dist_a);
		abs_b  = dist_b[9] ? 10'(-dist_b) : 10'(dist_b);
		abs_c  = dist_c[9] ? 10'(-dist_c) : 10'(dist_c);
		if (abs_a <= abs_b && abs_a <= abs_c) begin
			paeth = left;
		end else if (abs_b <= abs_c) begin
			paeth = above;
		end else begin
			paeth = above_left;
		end
	end

	// Prediction by filter type; an unknown type predicts zero.
	always_comb begin
		avg_sum = {1'b0, left} + {1'b0, above};
		case (filt)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = left;
			FILT_UP:    pred = above;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
	end

	assign recon = filtered + pred;
	assign bad   = (filt == FILT_BAD);

endmodule

/* rtl/png_scanline_unfilter_core.sv */
// PNG scanline reconstruction for 8-bit RGBA. The block takes the inflated
// scanline stream one byte per transaction; the first byte of each row is
// the filter type, which yields no output, and every later byte yields one
// reconstructed byte, with row_end on the last byte of the row and
// bad_filter when the row's filter type is above 4 (such bytes pass
// unchanged). first_of_image restarts the row count and treats the row
// above as zeros. The block sustains one byte per clock cycle unless a
// stalled output holds it: the line store is a single memory read once
// per accepted byte and written once per reconstructed byte, and each
// accepted byte is registered in stage one and its result in the output
// register. The line store needs no clearing after reset. Program
// row_pixels only while the block is idle; cfg_ready is always high.
module png_scanline_unfilter_core
	import png_unf_pkg::*;
#(
	parameter int MAX_ROW_BYTES = 16384
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] row_pixels,
	input  logic             data_valid,
	output logic             data_stall,
	input  logic [7:0]       data_byte,
	input  logic             first_of_image,
	output logic             pixel_valid,
	input  logic             pixel_stall,
	output logic [7:0]       pixel_byte,
	output logic             row_end,
	output logic             bad_filter
);

	localparam int MAX_PIX = MAX_ROW_BYTES / PIXEL_BYTES;
	localparam int PW      = $clog2(MAX_PIX + 1);
	localparam int NW      = PW + 2;
	localparam int AW      = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
	localparam int XW      = (PW > CFG_W) ? PW : CFG_W;

	// Configuration register.
	logic [CFG_W-1:0] row_pixels_q;

	// Row tracking, updated as each byte is accepted.
	logic [NW-1:0] column_q;
	filter_t       filter_q;
	logic          first_row_q;

	// Stage one: accepted byte waiting for the line store data.
	logic          valid_s1;
	logic          data_s1;
	logic [7:0]    byte_s1;
	logic [AW-1:0] idx_s1;
	filter_t       filter_s1;
	logic          first_row_s1;
	logic          last_s1;

	// Line store and its registered read data.
	logic [7:0]    line_mem [MAX_ROW_BYTES];
	logic [7:0]    above_q;

	// Last four reconstructed and above-row bytes.
	logic [31:0]   left_q;
	logic [31:0]   upper_left_q;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_end_q;
	logic          out_bad_q;

	logic          accept;
	logic          advance;
	logic          col_zero;
	logic          first_eff;
	logic [XW-1:0] cfg_ext;
	logic [XW-1:0] pix_clamp;
	logic [NW-1:0] row_len;
	logic [NW-1:0] idx_full;
	logic          last_now;
	logic [7:0]    above_byte;
	logic [7:0]    recon;
	logic          bad;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pixels_q <= CFG_W'(1);
		end else if (cfg_valid) begin
			row_pixels_q <= row_pixels;
		end
	end

	// Row length in bytes, with zero taken as one pixel and saturation.
	always_comb begin
		cfg_ext = XW'(row_pixels_q);
		if (cfg_ext == '0) begin
			pix_clamp = XW'(1);
		end else if (cfg_ext > XW'(MAX_PIX)) begin
			pix_clamp = XW'(MAX_PIX);
		end else begin
			pix_clamp = cfg_ext;
		end
		row_len = {pix_clamp[PW-1:0], 2'b00};
	end

	// Stage one moves on unless its result is blocked by a full output.
	assign advance    = !data_s1 || !out_valid_q || !pixel_stall;
	assign data_stall = valid_s1 && !advance;
	assign accept     = data_valid && !data_stall;

	// Decode of the arriving byte against the row position.
	always_comb begin
		col_zero  = first_of_image || (column_q == '0);
		first_eff = first_of_image || first_row_q;
		last_now  = (column_q >= row_len);
		if (last_now) begin
			idx_full = row_len - NW'(1);
		end else begin
			idx_full = column_q - NW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			filter_q    <= FILT_NONE;
			first_row_q <= 1'b1;
		end else if (accept) begin
			if (col_zero) begin
				filter_q    <= (data_byte > 8'd4) ? FILT_BAD : filter_t'(data_byte[2:0]);
				column_q    <= NW'(1);
				first_row_q <= first_eff;
			end else if (last_now) begin
				column_q    <= '0;
				first_row_q <= 1'b0;
			end else begin
				column_q    <= column_q + NW'(1);
			end
		end
	end

	// Stage one control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			data_s1  <= !col_zero;
		end else if (advance) begin
			valid_s1 <= 1'b0;
			data_s1  <= 1'b0;
		end
	end

	// Stage one payload and the line store read.
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1      <= data_byte;
			idx_s1       <= idx_full[AW-1:0];
			filter_s1    <= filter_q;
			first_row_s1 <= first_eff;
			last_s1      <= last_now;
			above_q      <= line_mem[idx_full[AW-1:0]];
		end
	end

	assign above_byte = first_row_s1 ? 8'd0 : above_q;

	png_unf_predict u_predict (
		.filt       (filter_s1),
		.filtered   (byte_s1),
		.left       (left_q[31:24]),
		.above      (above_byte),
		.above_left (upper_left_q[31:24]),
		.recon      (recon),
		.bad        (bad)
	);

	// Line store write of the reconstructed byte.
	always_ff @(posedge clk) begin
		if (valid_s1 && data_s1 && advance) begin
			line_mem[idx_s1] <= recon;
		end
	end

	// History of the current row; a filter byte clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (valid_s1 && advance) begin
			if (data_s1) begin
				left_q       <= {left_q[23:0], recon};
				upper_left_q <= {upper_left_q[23:0], above_byte};
			end else begin
				left_q       <= '0;
				upper_left_q <= '0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && data_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (!pixel_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && data_s1 && advance) begin
			out_byte_q <= recon;
			out_end_q  <= last_s1;
			out_bad_q  <= bad;
		end
	end

	assign pixel_valid = out_valid_q;
	assign pixel_byte  = out_byte_q;
	assign row_end     = out_end_q;
	assign bad_filter  = out_bad_q;

endmodule
